>>> rtl/rmvd_pkg.sv
package rmvd_pkg;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_AW-1:0] REG_RING_LEN   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_AVG_WIN    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_INTEG_WIN  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_THRESHOLD  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_USE_SMOOTH = 3'd4;
	localparam logic [CFG_AW-1:0] REG_THR_EN     = 3'd5;
	localparam logic [CFG_AW-1:0] REG_MIN_RSSI   = 3'd6;

	localparam logic [8:0]  RING_LEN_RST  = 9'd256;
	localparam logic [6:0]  AVG_WIN_RST   = 7'd64;
	localparam logic [8:0]  INTEG_WIN_RST = 9'd3;
	localparam logic [15:0] THRESHOLD_RST = 16'd3;
	localparam logic [7:0]  MIN_RSSI_RST  = 8'h9C;

	localparam logic signed [7:0] RSSI_FLOOR = -8'sd120;
	localparam logic signed [7:0] RSSI_CEIL  = 8'sd0;

	// result word
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 24;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFFFFFF;

	localparam logic [STATUS_W-1:0] ST_LEVEL = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BOOT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LOW   = 2'd2;

	typedef struct packed {
		logic                take;
		logic                s_rd;
		logic                s_upd;
		logic                d_rd;
		logic                div_start;
		logic                mag_ld;
		logic                sq_ld;
		logic                d_upd;
		logic                smooth;
		logic                out_ld;
		logic [STATUS_W-1:0] out_status;
		logic                clr_step;
	} cmd_t;

	typedef struct packed {
		logic low;
		logic boot;
		logic div_done;
		logic clr_last;
		logic restart;
	} stat_t;

endpackage

>>> rtl/rmvd_ctrl.sv
module rmvd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	input  rmvd_pkg::stat_t stat,
	output rmvd_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_SRD    = 4'd3;
	localparam logic [3:0] S_DIVS   = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_DUPD   = 4'd7;
	localparam logic [3:0] S_SMTH   = 4'd8;
	localparam logic [3:0] S_RESULT = 4'd9;

	logic [3:0]                    state_q, state_d;
	logic [rmvd_pkg::STATUS_W-1:0] res_q, res_d;
	logic                          mvalid_q;
	logic                          out_free;
	logic                          in_rdy;

	assign out_free      = !mvalid_q || m_axis_tready;
	assign in_rdy        = (state_q == S_IDLE) && !stat.restart;
	assign s_axis_tready = in_rdy;
	assign m_axis_tvalid = mvalid_q;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_axis_tvalid && in_rdy) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.low) begin
					state_d = S_RESULT;
					res_d   = rmvd_pkg::ST_LOW;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				if (stat.boot) begin
					state_d = S_RESULT;
					res_d   = rmvd_pkg::ST_BOOT;
				end else begin
					state_d = S_DIVS;
				end
			end
			S_DIVS: state_d = S_DIV;
			S_DIV: begin
				if (stat.div_done) state_d = S_MUL;
			end
			S_MUL:  state_d = S_DUPD;
			S_DUPD: state_d = S_SMTH;
			S_SMTH: begin
				state_d = S_RESULT;
				res_d   = rmvd_pkg::ST_LEVEL;
			end
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
		// a geometry write restarts the detector and sweeps the deviation ring
		if (stat.restart) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			res_q    <= rmvd_pkg::ST_LEVEL;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.out_ld) begin
				mvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.take       = s_axis_tvalid && in_rdy;
		cmd.s_rd       = (state_q == S_CHECK);
		cmd.s_upd      = (state_q == S_SRD);
		cmd.d_rd       = (state_q == S_SRD);
		cmd.div_start  = (state_q == S_DIVS);
		cmd.mag_ld     = (state_q == S_DIV) && stat.div_done;
		cmd.sq_ld      = (state_q == S_MUL);
		cmd.d_upd      = (state_q == S_DUPD);
		cmd.smooth     = (state_q == S_SMTH);
		cmd.out_ld     = (state_q == S_RESULT) && out_free;
		cmd.out_status = res_q;
		cmd.clr_step   = (state_q == S_CLEAR);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) && !out_free |=> (state_q == S_RESULT) || (state_q == S_CLEAR))
		else $error("result dropped while output word stalled");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == S_CHECK) || (state_q == S_CLEAR))
		else $error("accepted word not checked");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> mvalid_q)
		else $error("output register loaded without valid");

endmodule

>>> rtl/rmvd_dp.sv
module rmvd_dp #(
	parameter int RING_DEPTH  = 256,
	parameter int AVERAGE_MAX = 64,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rmvd_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [rmvd_pkg::CFG_DW-1:0]     cfg_wdata,
	input  logic [SAMPLE_BITS-1:0]          in_sample,
	input  rmvd_pkg::cmd_t                  cmd,
	output rmvd_pkg::stat_t                 stat,
	output logic [rmvd_pkg::STATUS_W-1:0]   out_status,
	output logic [rmvd_pkg::LEVEL_W-1:0]    out_level
);

	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LEN_W  = $clog2(RING_DEPTH + 1);
	localparam int AW_W   = $clog2(AVERAGE_MAX + 1);
	localparam int CW     = ((LEN_W > 9) ? LEN_W : 9) + 1;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(AVERAGE_MAX) + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int DCNT_W = $clog2(MAG_W + 1);
	localparam int DEV_W  = 2 * SAMPLE_BITS;
	localparam int DSUM_W = DEV_W + $clog2(RING_DEPTH);
	localparam int EXT_W  = (DSUM_W > rmvd_pkg::LEVEL_W) ? DSUM_W : rmvd_pkg::LEVEL_W;

	// configuration registers
	logic [8:0]  ring_len_q;
	logic [6:0]  avg_win_q;
	logic [8:0]  integ_win_q;
	logic [15:0] thr_q;
	logic        use_smooth_q;
	logic        thr_en_q;
	logic [7:0]  min_rssi_q;

	logic [LEN_W-1:0] len_q;
	logic [AW_W-1:0]  aw_q;
	logic [LEN_W-1:0] iw_q;

	logic [SAMPLE_BITS-1:0] smem [RING_DEPTH];
	logic [DEV_W-1:0]       dmem [RING_DEPTH];

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0]        srd_q;
	logic [DEV_W-1:0]              drd_q;
	logic [IDX_W-1:0]              widx_q;
	logic                          wrapped_q;
	logic signed [SUM_W-1:0]       ssum_q;
	logic [IDX_W-1:0]              didx_q;
	logic [DSUM_W-1:0]             dsum_q;
	logic [DSUM_W-1:0]             smooth_q;
	logic [IDX_W-1:0]              clr_q;

	logic [AW_W-1:0]        rem_q;
	logic [MAG_W-1:0]       quo_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [DEV_W-1:0]       dev_q;

	logic [rmvd_pkg::STATUS_W-1:0] out_status_q;
	logic [rmvd_pkg::LEVEL_W-1:0]  out_level_q;

	logic restart;
	logic clr_last;

	assign restart = cfg_we && (cfg_addr == rmvd_pkg::REG_RING_LEN ||
		cfg_addr == rmvd_pkg::REG_AVG_WIN || cfg_addr == rmvd_pkg::REG_INTEG_WIN);
	assign clr_last = (clr_q == IDX_W'(RING_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_len_q   <= rmvd_pkg::RING_LEN_RST;
			avg_win_q    <= rmvd_pkg::AVG_WIN_RST;
			integ_win_q  <= rmvd_pkg::INTEG_WIN_RST;
			thr_q        <= rmvd_pkg::THRESHOLD_RST;
			use_smooth_q <= 1'b0;
			thr_en_q     <= 1'b0;
			min_rssi_q   <= rmvd_pkg::MIN_RSSI_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				rmvd_pkg::REG_RING_LEN:   ring_len_q   <= cfg_wdata[8:0];
				rmvd_pkg::REG_AVG_WIN:    avg_win_q    <= cfg_wdata[6:0];
				rmvd_pkg::REG_INTEG_WIN:  integ_win_q  <= cfg_wdata[8:0];
				rmvd_pkg::REG_THRESHOLD:  thr_q        <= cfg_wdata[15:0];
				rmvd_pkg::REG_USE_SMOOTH: use_smooth_q <= cfg_wdata[0];
				rmvd_pkg::REG_THR_EN:     thr_en_q     <= cfg_wdata[0];
				rmvd_pkg::REG_MIN_RSSI:   min_rssi_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// effective geometry, registered; it only changes with a restart, which covers the register's lag
	logic [CW-1:0] rl_c, len_c, a_c, a1_c, aw_c, i_c, iw_c;
	always_comb begin
		rl_c  = CW'(ring_len_q);
		len_c = (rl_c == '0) ? CW'(1) :
			((rl_c > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : rl_c);
		a_c   = (avg_win_q == '0) ? CW'(1) : CW'(avg_win_q);
		a1_c  = (a_c > CW'(AVERAGE_MAX)) ? CW'(AVERAGE_MAX) : a_c;
		aw_c  = (a1_c > len_c) ? len_c : a1_c;
		i_c   = (integ_win_q == '0) ? CW'(1) : CW'(integ_win_q);
		iw_c  = (i_c > len_c) ? len_c : i_c;
	end

	always_ff @(posedge clk) begin
		len_q <= len_c[LEN_W-1:0];
		aw_q  <= aw_c[AW_W-1:0];
		iw_q  <= iw_c[LEN_W-1:0];
	end

	// minimum, clamped on use
	logic signed [7:0]             min_c;
	logic signed [SAMPLE_BITS-1:0] minv;
	always_comb begin
		min_c = $signed(min_rssi_q);
		if (min_c < rmvd_pkg::RSSI_FLOOR) min_c = rmvd_pkg::RSSI_FLOOR;
		if (min_c > rmvd_pkg::RSSI_CEIL)  min_c = rmvd_pkg::RSSI_CEIL;
		minv = SAMPLE_BITS'(min_c);
	end

	// ring addressing
	logic [CW-1:0]    widx_c, didx_c, lenq_c, awq_c, iwq_c;
	logic [CW-1:0]    sra_c, dra_c, stored_c, wnext_c, dnext_c;
	logic             wrapped_n;
	logic             drop_old;
	logic [IDX_W-1:0] s_raddr, d_raddr;
	always_comb begin
		widx_c    = CW'(widx_q);
		didx_c    = CW'(didx_q);
		lenq_c    = CW'(len_q);
		awq_c     = CW'(aw_q);
		iwq_c     = CW'(iw_q);
		sra_c     = (widx_c >= awq_c) ? widx_c - awq_c : widx_c + lenq_c - awq_c;
		dra_c     = (didx_c >= iwq_c) ? didx_c - iwq_c : didx_c + lenq_c - iwq_c;
		s_raddr   = sra_c[IDX_W-1:0];
		d_raddr   = dra_c[IDX_W-1:0];
		stored_c  = wrapped_q ? lenq_c : widx_c;
		drop_old  = (stored_c >= awq_c);
		wnext_c   = (widx_c + CW'(1) == lenq_c) ? '0 : widx_c + CW'(1);
		dnext_c   = (didx_c + CW'(1) == lenq_c) ? '0 : didx_c + CW'(1);
		wrapped_n = wrapped_q || (wnext_c == '0);
	end

	// sample ring
	always_ff @(posedge clk) begin
		if (cmd.s_upd) smem[widx_q] <= sample_q;
		if (cmd.s_rd)  srd_q <= smem[s_raddr];
	end

	// deviation ring: zero sweep, then update writes
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			dmem[clr_q] <= '0;
		end else if (cmd.d_upd) begin
			dmem[didx_q] <= dev_q;
		end
		if (cmd.d_rd) drd_q <= dmem[d_raddr];
	end

	logic signed [SUM_W-1:0] old_c;
	logic signed [SUM_W-1:0] ssum_n;
	assign old_c  = drop_old ? SUM_W'($signed(srd_q)) : '0;
	assign ssum_n = ssum_q - old_c + SUM_W'(sample_q);

	logic [DSUM_W:0] smooth_sum;
	assign smooth_sum = {1'b0, dsum_q} + {1'b0, smooth_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q    <= '0;
			wrapped_q <= 1'b0;
			ssum_q    <= '0;
			didx_q    <= '0;
			dsum_q    <= '0;
			smooth_q  <= '0;
			clr_q     <= '0;
		end else if (restart) begin
			widx_q    <= '0;
			wrapped_q <= 1'b0;
			ssum_q    <= '0;
			didx_q    <= '0;
			dsum_q    <= '0;
			smooth_q  <= '0;
			clr_q     <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_last ? '0 : clr_q + IDX_W'(1);
			if (cmd.s_upd) begin
				ssum_q    <= ssum_n;
				widx_q    <= wnext_c[IDX_W-1:0];
				wrapped_q <= wrapped_n;
			end
			if (cmd.d_upd) begin
				dsum_q <= dsum_q - DSUM_W'(drd_q) + DSUM_W'(dev_q);
				didx_q <= dnext_c[IDX_W-1:0];
			end
			if (cmd.smooth) smooth_q <= smooth_sum[DSUM_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) sample_q <= $signed(in_sample);
	end

	// restoring divider for |sum| / window, one quotient bit per cycle
	logic [AW_W:0] shift_c;
	logic [AW_W:0] trial;
	assign shift_c = {rem_q, quo_q[MAG_W-1]};
	assign trial   = shift_c - {1'b0, aw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= DCNT_W'(MAG_W);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	logic [SUM_W-1:0] abs_sum;
	assign abs_sum = ssum_q[SUM_W-1] ? SUM_W'(-ssum_q) : SUM_W'(ssum_q);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= abs_sum[MAG_W-1:0];
			neg_q <= ssum_q[SUM_W-1];
		end else if (dcnt_q != '0) begin
			if (!trial[AW_W]) begin
				rem_q <= trial[AW_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shift_c[AW_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	// deviation from the truncated mean, then square
	logic signed [SUM_W-1:0] mean_c, diff_c, absd_c;
	always_comb begin
		mean_c = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		diff_c = SUM_W'(sample_q) - mean_c;
		absd_c = diff_c[SUM_W-1] ? -diff_c : diff_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.mag_ld) mag_q <= absd_c[SAMPLE_BITS-1:0];
		if (cmd.sq_ld)  dev_q <= mag_q * mag_q;
	end

	// level select, threshold, saturate
	logic [EXT_W-1:0] lvl_c;
	always_comb begin
		lvl_c = use_smooth_q ? EXT_W'(smooth_q) : EXT_W'(dsum_q);
		if (thr_en_q && lvl_c < EXT_W'(thr_q)) lvl_c = '0;
		if (lvl_c > EXT_W'(rmvd_pkg::LEVEL_MAX)) lvl_c = EXT_W'(rmvd_pkg::LEVEL_MAX);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_status_q <= cmd.out_status;
			out_level_q  <= (cmd.out_status == rmvd_pkg::ST_LEVEL) ?
				lvl_c[rmvd_pkg::LEVEL_W-1:0] : '0;
		end
	end

	assign out_status = out_status_q;
	assign out_level  = out_level_q;

	always_comb begin
		stat          = '0;
		stat.low      = (sample_q < minv);
		stat.boot     = !wrapped_n && (wnext_c < awq_c);
		stat.div_done = (dcnt_q == '0);
		stat.clr_last = clr_last;
		stat.restart  = restart;
	end

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.s_upd |-> (widx_c < lenq_c))
		else $error("sample index beyond ring length");

	a_didx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.d_upd |-> (didx_c < lenq_c))
		else $error("deviation index beyond ring length");

	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (dcnt_q == DCNT_W'(MAG_W)))
		else $error("divider not loaded");

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld && (cmd.out_status != rmvd_pkg::ST_LEVEL) |=> (out_level_q == '0))
		else $error("nonzero level on booting or rejected word");

endmodule

>>> rtl/rssi_motion_variance_detector.sv
// Each accepted word runs CHECK then RESULT when rejected, CHECK, SRD, RESULT while
// booting, and CHECK, SRD, DIVS, DIV, MUL, DUPD, SMTH, RESULT for a level.
// Throughput: one word at a time, the next word taken once the controller is back in
// idle after the result is loaded; the serial mean divider is the longest step.
// Reset, and any write to ring_length, average_window or integrator_window,
// zeroes every deviation ring entry in a sweep while no word is accepted.
module rssi_motion_variance_detector #(
	parameter int RING_DEPTH  = 256,
	parameter int AVERAGE_MAX = 64,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // rssi_sample
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [rmvd_pkg::LEVEL_W-1:0]          m_axis_tdata,  // motion_level
	output logic [rmvd_pkg::STATUS_W-1:0]         m_axis_tuser,  // status
	input  logic                                  cfg_we,
	input  logic [rmvd_pkg::CFG_AW-1:0]           cfg_addr,
	input  logic [rmvd_pkg::CFG_DW-1:0]           cfg_wdata
);

	rmvd_pkg::cmd_t  cmd;
	rmvd_pkg::stat_t stat;

	rmvd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	rmvd_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.AVERAGE_MAX (AVERAGE_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (m_axis_tuser),
		.out_level  (m_axis_tdata)
	);

endmodule

>>> tb/rmvd_level_checker.sv
module rmvd_level_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [rmvd_pkg::LEVEL_W-1:0]  m_tdata,
	input  logic [rmvd_pkg::STATUS_W-1:0] m_tuser,
	input  logic                          cfg_we,
	input  logic [rmvd_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [rmvd_pkg::CFG_DW-1:0]   cfg_wdata,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH   = 256;
	localparam int AVG_CAP = 64;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [rmvd_pkg::STATUS_W-1:0] status;
		logic [rmvd_pkg::LEVEL_W-1:0]  level;
	} motion_word_t;

	logic [8:0]  ring_len;
	logic [6:0]  avg_win;
	logic [8:0]  integ_win;
	logic [15:0] threshold;
	logic        smooth_sel;
	logic        thr_en;
	logic [7:0]  min_rssi;

	logic signed [7:0] sample_ring [DEPTH];
	logic [15:0]       dev_ring [DEPTH];
	int smp_idx;
	bit smp_wrapped;
	int smp_sum;
	int dev_idx;
	int dev_sum;
	int smoothed;

	motion_word_t expected_words[$];
	int fail_cnt;
	int word_cnt;

	function automatic int clamp_window(int w, int cap);
		if (w < 1) w = 1;
		if (w > cap) w = cap;
		return w;
	endfunction

	task automatic restart_detector();
		for (int i = 0; i < DEPTH; i++) begin
			sample_ring[i] = '0;
			dev_ring[i] = '0;
		end
		smp_idx = 0;
		smp_wrapped = 1'b0;
		smp_sum = 0;
		dev_idx = 0;
		dev_sum = 0;
		smoothed = 0;
	endtask

	task automatic log_mismatch(input string what);
		fail_cnt++;
		if (fail_cnt <= REPORT_MAX)
			$display("%0t ns: %s", $realtime, what);
	endtask

	task automatic predict_motion(input logic signed [7:0] smp, output motion_word_t word);
		int len, aw, iw, widx, stored, minv, mean, diff, dev, didx, lvl;
		word.status = rmvd_pkg::ST_LEVEL;
		word.level = '0;
		minv = int'($signed(min_rssi));
		if (minv < rmvd_pkg::RSSI_FLOOR) minv = rmvd_pkg::RSSI_FLOOR;
		if (minv > rmvd_pkg::RSSI_CEIL) minv = rmvd_pkg::RSSI_CEIL;
		if (smp < minv) begin
			word.status = rmvd_pkg::ST_LOW;
			return;
		end
		len = clamp_window(int'(ring_len), DEPTH);
		aw = clamp_window(clamp_window(int'(avg_win), AVG_CAP), len);
		iw = clamp_window(int'(integ_win), len);

		// drop the oldest sample once the mean window is full
		widx = smp_idx % len;
		stored = smp_wrapped ? len : widx;
		if (stored >= aw)
			smp_sum = smp_sum - int'(sample_ring[(widx + len - aw) % len]);
		smp_sum = smp_sum + int'(smp);
		sample_ring[widx] = smp;
		widx = (widx + 1) % len;
		smp_idx = widx;
		if (!smp_wrapped && widx == 0) smp_wrapped = 1'b1;
		if (!smp_wrapped && widx < aw) begin
			word.status = rmvd_pkg::ST_BOOT;
			return;
		end

		mean = smp_sum / aw;
		diff = int'(smp) - mean;
		dev = diff * diff;
		didx = dev_idx % len;
		dev_sum = dev_sum - int'(dev_ring[(didx + len - iw) % len]) + dev;
		dev_ring[didx] = 16'(dev);
		dev_idx = (didx + 1) % len;
		smoothed = (dev_sum + smoothed) >>> 1;

		lvl = smooth_sel ? smoothed : dev_sum;
		if (thr_en && lvl < int'(threshold)) lvl = 0;
		if (lvl > int'(rmvd_pkg::LEVEL_MAX)) lvl = int'(rmvd_pkg::LEVEL_MAX);
		word.level = lvl[rmvd_pkg::LEVEL_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		motion_word_t want, got;
		if (!arst_n) begin
			ring_len = rmvd_pkg::RING_LEN_RST;
			avg_win = rmvd_pkg::AVG_WIN_RST;
			integ_win = rmvd_pkg::INTEG_WIN_RST;
			threshold = rmvd_pkg::THRESHOLD_RST;
			smooth_sel = 1'b0;
			thr_en = 1'b0;
			min_rssi = rmvd_pkg::MIN_RSSI_RST;
			restart_detector();
			expected_words.delete();
			fail_cnt = 0;
			word_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					rmvd_pkg::REG_RING_LEN: begin
						ring_len = cfg_wdata[8:0];
						restart_detector();
					end
					rmvd_pkg::REG_AVG_WIN: begin
						avg_win = cfg_wdata[6:0];
						restart_detector();
					end
					rmvd_pkg::REG_INTEG_WIN: begin
						integ_win = cfg_wdata[8:0];
						restart_detector();
					end
					rmvd_pkg::REG_THRESHOLD:  threshold = cfg_wdata[15:0];
					rmvd_pkg::REG_USE_SMOOTH: smooth_sel = cfg_wdata[0];
					rmvd_pkg::REG_THR_EN:     thr_en = cfg_wdata[0];
					rmvd_pkg::REG_MIN_RSSI:   min_rssi = cfg_wdata[7:0];
					default: ;
				endcase
			end

			// check results before predicting: a word can never come back in the cycle it went in
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.level = m_tdata;
				if (expected_words.size() == 0) begin
					log_mismatch($sformatf("word %0d with nothing pending: status %0d level %0d",
						word_cnt, got.status, got.level));
				end else begin
					want = expected_words.pop_front();
					if (want.status !== got.status || want.level !== got.level)
						log_mismatch($sformatf(
							"word %0d: status exp %0d got %0d, level exp %0d got %0d",
							word_cnt, want.status, got.status, want.level, got.level));
				end
				word_cnt++;
			end

			if (s_tvalid && s_tready) begin
				predict_motion(s_tdata, want);
				expected_words.push_back(want);
			end

			errors <= fail_cnt;
			pending <= expected_words.size();
		end
	end

endmodule

>>> tb/rssi_motion_variance_detector_tb.sv
module rssi_motion_variance_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS  = 1450;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_SETTLE = 4;
	localparam int END_SETTLE   = 40;
	localparam int DEPTH        = 256;
	localparam int AVG_CAP      = 64;
	localparam logic [rmvd_pkg::CFG_AW-1:0] REG_NONE = 3'd7;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [rmvd_pkg::LEVEL_W-1:0]  m_axis_tdata;
	logic [rmvd_pkg::STATUS_W-1:0] m_axis_tuser;
	logic                          cfg_we = 1'b0;
	logic [rmvd_pkg::CFG_AW-1:0]   cfg_addr = '0;
	logic [rmvd_pkg::CFG_DW-1:0]   cfg_wdata = '0;

	int errors;
	int pending;
	int cycles = 0;
	int items_sent = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	rssi_motion_variance_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	rmvd_level_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_reg(input logic [rmvd_pkg::CFG_AW-1:0] idx,
		input logic [rmvd_pkg::CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_sample(input logic [7:0] smp);
		int gap;
		s_axis_tdata <= smp;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// result side: random stalls, plus one long hold-off while words keep coming
	initial begin
		int stall;
		int taken;
		bit held;
		stall = 0;
		taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				taken++;
				if (taken % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
				stall = pick_gap(rx_calm);
			end else if (stall == 0 && !m_axis_tvalid && $urandom_range(0, 15) == 0) begin
				stall = pick_gap(rx_calm);
			end
			if (!held && taken >= HOLD_AFTER && s_axis_tvalid) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int r, phase, count, len_eff, aw_eff, min_eff, base, spread;
		bit geometry;
		logic [8:0] ring_v;
		logic [6:0] avg_v;
		logic [8:0] integ_v;
		logic [7:0] min_v;
		logic [7:0] smp;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short ring, lowest minimum: full sample range, rejects at the floor edge
		write_reg(rmvd_pkg::REG_RING_LEN, 16'd4);
		write_reg(rmvd_pkg::REG_AVG_WIN, 16'd2);
		write_reg(rmvd_pkg::REG_INTEG_WIN, 16'd3);
		write_reg(rmvd_pkg::REG_MIN_RSSI, 16'h0088);
		offer_sample(8'h80);
		offer_sample(8'h87);
		offer_sample(8'h88);
		offer_sample(8'h7F);
		offer_sample(8'h88);
		offer_sample(8'h7F);
		offer_sample(8'h00);
		offer_sample(8'hFF);
		drain(PHASE_SETTLE);

		// minimum above ceiling acts as zero; smoother with top threshold, no restart
		write_reg(rmvd_pkg::REG_MIN_RSSI, 16'h007F);
		write_reg(rmvd_pkg::REG_USE_SMOOTH, 16'd1);
		write_reg(rmvd_pkg::REG_THR_EN, 16'd1);
		write_reg(rmvd_pkg::REG_THRESHOLD, 16'hFFFF);
		offer_sample(8'hFF);
		offer_sample(8'h00);
		offer_sample(8'h00);
		drain(PHASE_SETTLE);

		// zero windows act as one, unknown index ignored, minimum below floor clamps
		write_reg(rmvd_pkg::REG_RING_LEN, 16'd0);
		write_reg(rmvd_pkg::REG_AVG_WIN, 16'd0);
		write_reg(rmvd_pkg::REG_INTEG_WIN, 16'd0);
		write_reg(REG_NONE, 16'hFFFF);
		write_reg(rmvd_pkg::REG_MIN_RSSI, 16'h0080);
		write_reg(rmvd_pkg::REG_THRESHOLD, 16'd0);
		offer_sample(8'h7F);
		offer_sample(8'h88);
		offer_sample(8'h05);
		drain(PHASE_SETTLE);

		// windows longer than the ring clamp to it
		write_reg(rmvd_pkg::REG_RING_LEN, 16'd3);
		write_reg(rmvd_pkg::REG_AVG_WIN, 16'd100);
		write_reg(rmvd_pkg::REG_INTEG_WIN, 16'd300);
		write_reg(rmvd_pkg::REG_THRESHOLD, 16'd1);
		write_reg(rmvd_pkg::REG_USE_SMOOTH, 16'd0);
		offer_sample(8'h0A);
		offer_sample(8'hF6);
		offer_sample(8'h1E);
		offer_sample(8'h9C);
		drain(PHASE_SETTLE);

		len_eff = 3;
		aw_eff = 3;
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			geometry = (phase == 0) || ($urandom_range(0, 9) < 6);
			if (geometry) begin
				if (phase == 0) begin
					ring_v = 9'd256;
					avg_v = 7'd64;
					integ_v = 9'd256;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 65) ring_v = 9'($urandom_range(1, 24));
					else if (r < 80) ring_v = 9'($urandom_range(25, 255));
					else if (r < 88) ring_v = 9'd256;
					else if (r < 94) ring_v = 9'($urandom_range(257, 511));
					else ring_v = 9'd0;
					r = $urandom_range(0, 99);
					if (r < 60) avg_v = 7'($urandom_range(1, 12));
					else if (r < 70) avg_v = 7'd0;
					else if (r < 85) avg_v = 7'($urandom_range(13, 64));
					else avg_v = 7'($urandom_range(65, 127));
				end
				len_eff = (ring_v == 0) ? 1 : (ring_v > DEPTH) ? DEPTH : int'(ring_v);
				if (phase != 0) begin
					if ($urandom_range(0, 9) < 7) integ_v = 9'($urandom_range(0, len_eff + 4));
					else integ_v = 9'($urandom_range(0, 511));
				end
				aw_eff = (avg_v == 0) ? 1 : (avg_v > AVG_CAP) ? AVG_CAP : int'(avg_v);
				if (aw_eff > len_eff) aw_eff = len_eff;
				write_reg(rmvd_pkg::REG_RING_LEN, rmvd_pkg::CFG_DW'(ring_v));
				write_reg(rmvd_pkg::REG_AVG_WIN, rmvd_pkg::CFG_DW'(avg_v));
				write_reg(rmvd_pkg::REG_INTEG_WIN, rmvd_pkg::CFG_DW'(integ_v));
				count = aw_eff + $urandom_range(5, 60);
			end else begin
				count = $urandom_range(10, 60);
			end

			r = $urandom_range(0, 9);
			if (r == 0) write_reg(rmvd_pkg::REG_THRESHOLD, 16'd0);
			else if (r == 1) write_reg(rmvd_pkg::REG_THRESHOLD, 16'hFFFF);
			else if (r < 6) write_reg(rmvd_pkg::REG_THRESHOLD,
				rmvd_pkg::CFG_DW'($urandom_range(0, 2000)));
			else write_reg(rmvd_pkg::REG_THRESHOLD, rmvd_pkg::CFG_DW'($urandom));
			write_reg(rmvd_pkg::REG_USE_SMOOTH, rmvd_pkg::CFG_DW'($urandom_range(0, 1)));
			write_reg(rmvd_pkg::REG_THR_EN, rmvd_pkg::CFG_DW'($urandom_range(0, 1)));
			if ($urandom_range(0, 99) < 15) min_v = 8'($urandom);
			else min_v = 8'(-120 + int'($urandom_range(0, 120)));
			write_reg(rmvd_pkg::REG_MIN_RSSI, rmvd_pkg::CFG_DW'(min_v));

			min_eff = int'($signed(min_v));
			if (min_eff < -120) min_eff = -120;
			if (min_eff > 0) min_eff = 0;
			spread = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
			base = min_eff + $urandom_range(0, 127 - spread - min_eff);

			// mostly a plausible signal around one level, some raw noise
			repeat (count) begin
				if ($urandom_range(0, 9) == 0) smp = 8'($urandom);
				else smp = 8'(base + int'($urandom_range(0, spread)));
				offer_sample(smp);
			end
			drain(PHASE_SETTLE);
			phase++;
		end

		drain(END_SETTLE);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
